/* sv/deq_pkg.sv */
package deq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int KIND_W    = 3;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 2;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DUMP       = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // latch the incoming beat
    logic exec;  // carry out the operation on pointers and storage
    logic rd;    // read the slot at the current offset
    logic step;  // move the dump cursor to the next element
  } deq_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              empty;
    logic              last;
  } deq_sts_t;

endpackage

/* sv/deq_if.sv */
interface deq_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [deq_pkg::KIND_W-1:0]           kind;
  logic signed [deq_pkg::VALUE_W-1:0]   value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface deq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [deq_pkg::VALUE_W-1:0]   element;
  logic [deq_pkg::STATUS_W-1:0]         status;
  logic                                 backward;
  logic                                 last;

  modport source (output valid, output element, output status, output backward,
                  output last, input ready);
  modport sink   (input valid, input element, input status, input backward,
                  input last, output ready);
endinterface

/* sv/deq_ctrl.sv */
module deq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  deq_pkg::deq_sts_t sts,
  output deq_pkg::deq_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;
  localparam logic [1:0] S_RD   = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.kind inside {deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_POP_BACK,
                             deq_pkg::KIND_DUMP}) begin
          cmd.rd    = !sts.empty;
          state_nxt = S_OUT;
        end else if (sts.kind inside {deq_pkg::KIND_PUSH_FRONT,
                                      deq_pkg::KIND_PUSH_BACK}) begin
          state_nxt = S_OUT;
        end else begin
          // Unknown codes produce nothing.
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          if (sts.last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.step  = 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_OUT;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* sv/deq_dp.sv */
module deq_dp #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  deq_pkg::deq_cmd_t                   cmd,
  output deq_pkg::deq_sts_t                   sts,
  input  logic [deq_pkg::KIND_W-1:0]          in_kind,
  input  logic signed [deq_pkg::VALUE_W-1:0]  in_value,
  output logic signed [deq_pkg::VALUE_W-1:0]  out_element,
  output logic [deq_pkg::STATUS_W-1:0]        out_status,
  output logic                                out_backward,
  output logic                                out_last
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW:0]   DEPTH_X   = (PW+1)'(DEPTH);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  logic [deq_pkg::VALUE_W-1:0] mem [DEPTH];

  logic [PW-1:0]                 head_r;
  logic [CW-1:0]                 count_r;
  logic [deq_pkg::KIND_W-1:0]    kind_r;
  logic [deq_pkg::VALUE_W-1:0]   value_r;
  logic [PW-1:0]                 idx_r;
  logic                          back_r;
  logic [deq_pkg::VALUE_W-1:0]   rdata_r;
  logic [deq_pkg::STATUS_W-1:0]  status_r;
  logic [deq_pkg::STATUS_W-1:0]  status_nxt;

  logic          empty;
  logic          full;
  logic [CW-1:0] cnt_dec;
  logic [PW-1:0] head_dec;
  logic [PW-1:0] head_inc;
  logic [PW-1:0] off;
  logic [PW:0]   sum;
  logic [PW:0]   wrap;
  logic [PW-1:0] addr;
  logic          wr_en;
  logic [PW-1:0] wr_addr;
  logic          is_read_op;

  assign empty    = (count_r == '0);
  assign full     = (count_r == FULL_CNT);
  assign cnt_dec  = count_r - CW'(1);
  assign head_dec = (head_r == '0) ? LAST_SLOT : head_r - PW'(1);
  assign head_inc = (head_r == LAST_SLOT) ? '0 : head_r + PW'(1);

  // Offset from the front, then folded back into the ring.
  always_comb begin
    unique case (kind_r)
      deq_pkg::KIND_PUSH_BACK: off = count_r[PW-1:0];
      deq_pkg::KIND_POP_BACK:  off = cnt_dec[PW-1:0];
      deq_pkg::KIND_DUMP:      off = idx_r;
      default:                 off = '0;
    endcase
  end

  assign sum  = {1'b0, head_r} + {1'b0, off};
  assign wrap = (sum >= DEPTH_X) ? sum - DEPTH_X : sum;
  assign addr = wrap[PW-1:0];

  assign wr_en   = cmd.exec && !full && (kind_r == deq_pkg::KIND_PUSH_FRONT ||
                                         kind_r == deq_pkg::KIND_PUSH_BACK);
  assign wr_addr = (kind_r == deq_pkg::KIND_PUSH_FRONT) ? head_dec : addr;

  always_comb begin
    unique case (kind_r)
      deq_pkg::KIND_PUSH_FRONT,
      deq_pkg::KIND_PUSH_BACK: status_nxt = full ? deq_pkg::ST_FULL : deq_pkg::ST_OK;
      default:                 status_nxt = empty ? deq_pkg::ST_EMPTY : deq_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rdata_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      unique case (kind_r)
        deq_pkg::KIND_PUSH_FRONT: begin
          if (!full) begin
            head_r  <= head_dec;
            count_r <= count_r + CW'(1);
          end
        end
        deq_pkg::KIND_PUSH_BACK: begin
          if (!full) begin
            count_r <= count_r + CW'(1);
          end
        end
        deq_pkg::KIND_POP_FRONT: begin
          if (!empty) begin
            head_r  <= head_inc;
            count_r <= cnt_dec;
          end
        end
        deq_pkg::KIND_POP_BACK: begin
          if (!empty) begin
            count_r <= cnt_dec;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_kind;
      value_r <= in_value;
      idx_r   <= '0;
      back_r  <= 1'b0;
    end else if (cmd.step) begin
      if (!back_r && idx_r == cnt_dec[PW-1:0]) begin
        back_r <= 1'b1;
      end else if (!back_r) begin
        idx_r <= idx_r + PW'(1);
      end else begin
        idx_r <= idx_r - PW'(1);
      end
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
    end
  end

  assign is_read_op = (kind_r == deq_pkg::KIND_POP_FRONT ||
                       kind_r == deq_pkg::KIND_POP_BACK ||
                       kind_r == deq_pkg::KIND_DUMP);

  assign out_element  = (is_read_op && status_r == deq_pkg::ST_OK) ? rdata_r : '0;
  assign out_status   = status_r;
  assign out_backward = back_r;
  assign out_last     = (kind_r != deq_pkg::KIND_DUMP) ||
                        (status_r != deq_pkg::ST_OK) ||
                        (back_r && idx_r == '0);

  assign sts.kind  = kind_r;
  assign sts.empty = empty;
  assign sts.last  = out_last;

endmodule

/* sv/double_ended_queue.sv */
// Channel | Dir | Handshake      | Payload
// in_ch   | in  | valid / ready  | kind[2:0], value[31:0] signed
// out_ch  | out | valid / ready  | element[31:0] signed, status[1:0], backward, last
//
// A push or a pop passes the idle, execute and output states of the controller;
// a dump adds a read state before each of its further result beats, and a dump
// of an empty queue gives a single beat with the empty status.
// The sequence is set by the state machine and by the single read port of the
// slot memory, whose read data is registered before it reaches the output.
// Reset is synchronous and active low; it empties the queue. Slot contents are
// not cleared, since only live slots are ever read.
// A stalled result holds its payload, and no input beat is taken until the
// last result of the current item has been delivered.
module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  deq_in_if.sink     in_ch,
  deq_out_if.source  out_ch
);

  // The controller only sequences; all pointer arithmetic, the slot memory and
  // the result fields live in the datapath.
  deq_pkg::deq_cmd_t cmd;
  deq_pkg::deq_sts_t sts;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Each result beat is built from registered fields, so it stays steady for
  // as long as the sink holds ready low.
  deq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_kind      (in_ch.kind),
    .in_value     (in_ch.value),
    .out_element  (out_ch.element),
    .out_status   (out_ch.status),
    .out_backward (out_ch.backward),
    .out_last     (out_ch.last)
  );

`ifndef NO_ASSERTIONS
  // One item at a time: the block never takes a beat while a result is shown.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input taken while a result is pending");

  // A result that is not ok carries no element.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != deq_pkg::ST_OK) |-> (out_ch.element == '0))
    else $error("failed operation returned an element");

  // The back-to-front pass only exists for a dump of a non-empty queue.
  a_back_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.backward) |-> (out_ch.status == deq_pkg::ST_OK))
    else $error("backward beat with a failure status");

  // Once the final result of an item is taken, the next input is welcome.
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last) |=> in_ch.ready)
    else $error("block not ready after the final result");
`endif

endmodule

/* tb/sv/tb.sv */
// Self-checking bench for the double-ended queue.
// A short table of directed operations runs first. It covers the empty queue,
// the spare operation codes, the extreme values and the removal of the only
// element. Random episodes follow. They fill the queue past full, drain it past
// empty, mix operations at random and dump it. Every accepted input beat is run
// through a local model of the queue, which queues up the result beats it
// should cause. The output monitor checks each delivered beat against the
// oldest of these.
module tb;
  import deq_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int PTR_W       = $clog2(DEPTH);
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_OPS  = 120;
  localparam int DRAIN_WAIT  = 20;

  // Operation codes that the block must ignore without giving a result.
  localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_C = 3'd7;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [PTR_W:0]   fill_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] element;
    logic [STATUS_W-1:0]       status;
    logic                      backward;
    logic                      last;
  } deq_result_t;

  // One row of the directed table. Where typed is set, the row gives exactly
  // one result, and want holds it as read straight off the specification.
  typedef struct {
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] value;
    bit                        typed;
    deq_result_t               want;
  } op_row_t;

  logic clk;
  logic rst_n;

  deq_in_if  in_bus ();
  deq_out_if out_bus ();

  double_ended_queue #(.DEPTH(DEPTH)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  // Local copy of the queue: slot storage, front index and fill level.
  logic signed [VALUE_W-1:0] slot_mem [DEPTH];
  ptr_t                      front_idx;
  fill_t                     fill;

  deq_result_t pending_results [$];
  deq_result_t got_beat;
  deq_result_t want_beat;

  int  errors    = 0;
  int  cycle_cnt = 0;
  int  out_wait  = 0;
  bit  out_taken = 1'b0;
  // While calm is set neither side idles, so the block is run back to back.
  bit  calm      = 1'b0;

  op_row_t directed_ops [19];

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic deq_result_t make_result(
      input logic signed [VALUE_W-1:0] element,
      input logic [STATUS_W-1:0]       status,
      input logic                      backward,
      input logic                      last);
    deq_result_t r;
    r.element  = element;
    r.status   = status;
    r.backward = backward;
    r.last     = last;
    return r;
  endfunction

  // Slot that lies the given number of places behind the front of the queue.
  function automatic ptr_t slot_of(input int offset);
    return ptr_t'((int'(front_idx) + offset) % DEPTH);
  endfunction

  // Carries out one operation on the local queue and records the result beats
  // that it must cause, in order.
  function void apply_op(input logic [KIND_W-1:0] kind,
                         input logic signed [VALUE_W-1:0] value);
    int i;
    case (kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (fill == DEPTH) begin
          pending_results.push_back(make_result('0, ST_FULL, 1'b0, 1'b1));
        end else begin
          if (kind == KIND_PUSH_FRONT) begin
            front_idx = slot_of(DEPTH - 1);
            slot_mem[front_idx] = value;
          end else begin
            slot_mem[slot_of(int'(fill))] = value;
          end
          fill = fill + fill_t'(1);
          pending_results.push_back(make_result('0, ST_OK, 1'b0, 1'b1));
        end
      end
      KIND_POP_FRONT, KIND_POP_BACK: begin
        if (fill == 0) begin
          pending_results.push_back(make_result('0, ST_EMPTY, 1'b0, 1'b1));
        end else begin
          if (kind == KIND_POP_FRONT) begin
            pending_results.push_back(
                make_result(slot_mem[front_idx], ST_OK, 1'b0, 1'b1));
            front_idx = slot_of(1);
          end else begin
            pending_results.push_back(make_result(
                slot_mem[slot_of(int'(fill) - 1)], ST_OK, 1'b0, 1'b1));
          end
          fill = fill - fill_t'(1);
        end
      end
      KIND_DUMP: begin
        if (fill == 0) begin
          pending_results.push_back(make_result('0, ST_EMPTY, 1'b0, 1'b1));
        end else begin
          // Front to back first, then back to front; only the very last beat
          // of the return pass carries last.
          for (i = 0; i < int'(fill); i++) begin
            pending_results.push_back(make_result(
                slot_mem[slot_of(i)], ST_OK, 1'b0, 1'b0));
          end
          for (i = int'(fill) - 1; i >= 0; i--) begin
            pending_results.push_back(make_result(
                slot_mem[slot_of(i)], ST_OK, 1'b1, i == 0));
          end
        end
      end
      default: begin
        // Spare codes leave the queue alone and give nothing.
      end
    endcase
  endfunction

  // Mostly random words, with the extremes and the all-zero and all-one
  // patterns drawn now and then.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sh0000_0000;
      3:       return 32'shffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] pick_push();
    return $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
  endfunction

  function automatic logic [KIND_W-1:0] pick_pop();
    return $urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT;
  endfunction

  // Presents one input beat after a random idle gap and returns at the rising
  // edge at which the block takes it. Valid stays high between back-to-back
  // beats, so it is never lowered and raised again in the same time step.
  task automatic drive_op(input logic [KIND_W-1:0] kind,
                          input logic signed [VALUE_W-1:0] value);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_bus.valid <= 1'b1;
    in_bus.kind  <= kind;
    in_bus.value <= value;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  // Sends one random operation and updates the local queue with it.
  task automatic run_op(input logic [KIND_W-1:0] kind);
    logic signed [VALUE_W-1:0] value;
    value = pick_value();
    drive_op(kind, value);
    apply_op(kind, value);
  endtask

  // The result side: after each delivered beat the receiver draws how long it
  // stalls before it takes the next one. Ready changes only at the falling edge.
  always @(negedge clk) begin
    if (out_taken) begin
      out_wait  = calm ? 0 : $urandom_range(0, 7);
      out_taken = 1'b0;
    end
    if (out_wait > 0) begin
      out_bus.ready <= 1'b0;
      out_wait--;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // Output monitor and watchdog. Every beat taken at a rising edge is compared
  // field by field with the oldest expected beat.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: run stopped by the cycle limit with %0d beats outstanding",
               $time, pending_results.size());
      $display("FAILED: results differ");
      $finish;
    end else if (rst_n && out_bus.valid && out_bus.ready) begin
      out_taken         = 1'b1;
      got_beat.element  = out_bus.element;
      got_beat.status   = out_bus.status;
      got_beat.backward = out_bus.backward;
      got_beat.last     = out_bus.last;
      if (pending_results.size() == 0) begin
        errors++;
        $display({"%0t: unexpected result beat, expected none, ",
                  "got element %0d status %0d backward %0b last %0b"},
                 $time, got_beat.element, got_beat.status, got_beat.backward,
                 got_beat.last);
      end else begin
        want_beat = pending_results.pop_front();
        if (got_beat.element !== want_beat.element ||
            got_beat.status !== want_beat.status ||
            got_beat.backward !== want_beat.backward ||
            got_beat.last !== want_beat.last) begin
          errors++;
          $display({"%0t: result mismatch, ",
                    "expected element %0d status %0d backward %0b last %0b, ",
                    "got element %0d status %0d backward %0b last %0b"},
                   $time, want_beat.element, want_beat.status, want_beat.backward,
                   want_beat.last, got_beat.element, got_beat.status,
                   got_beat.backward, got_beat.last);
        end
      end
    end
  end

  initial begin
    int ops_sent;
    int n;
    int k;

    rst_n         = 1'b0;
    in_bus.valid  = 1'b0;
    in_bus.kind   = KIND_PUSH_FRONT;
    in_bus.value  = '0;
    out_bus.ready = 1'b0;
    front_idx     = '0;
    fill          = '0;
    foreach (slot_mem[j]) slot_mem[j] = '0;

    // The directed table. Typed rows hold the result as it can be read off the
    // specification; the remaining rows rely on the local model.
    directed_ops = '{
      // Pops and a dump on the queue straight after reset all report empty.
      '{KIND_POP_FRONT,  32'sh0000_0000, 1'b1, '{32'sh0, ST_EMPTY, 1'b0, 1'b1}},
      '{KIND_POP_BACK,   32'sh0000_0000, 1'b1, '{32'sh0, ST_EMPTY, 1'b0, 1'b1}},
      '{KIND_DUMP,       32'sh0000_0000, 1'b1, '{32'sh0, ST_EMPTY, 1'b0, 1'b1}},
      // Spare codes are swallowed without a result.
      '{KIND_SPARE_A,    32'shffff_ffff, 1'b0, '{32'sh0, ST_OK, 1'b0, 1'b0}},
      '{KIND_SPARE_B,    32'sh5555_5555, 1'b0, '{32'sh0, ST_OK, 1'b0, 1'b0}},
      '{KIND_SPARE_C,    32'shaaaa_aaaa, 1'b0, '{32'sh0, ST_OK, 1'b0, 1'b0}},
      // A single element removed from the opposite end, at both extremes.
      '{KIND_PUSH_FRONT, 32'sh8000_0000, 1'b1, '{32'sh0, ST_OK, 1'b0, 1'b1}},
      '{KIND_POP_BACK,   32'sh0000_0000, 1'b1, '{32'sh8000_0000, ST_OK, 1'b0, 1'b1}},
      '{KIND_PUSH_BACK,  32'sh7fff_ffff, 1'b1, '{32'sh0, ST_OK, 1'b0, 1'b1}},
      '{KIND_POP_FRONT,  32'sh0000_0000, 1'b1, '{32'sh7fff_ffff, ST_OK, 1'b0, 1'b1}},
      // A few elements, a dump of them, and removal from both ends.
      '{KIND_PUSH_BACK,  32'shffff_ffff, 1'b1, '{32'sh0, ST_OK, 1'b0, 1'b1}},
      '{KIND_PUSH_FRONT, 32'sh0000_0000, 1'b1, '{32'sh0, ST_OK, 1'b0, 1'b1}},
      '{KIND_PUSH_FRONT, 32'sh1234_5678, 1'b0, '{32'sh0, ST_OK, 1'b0, 1'b0}},
      '{KIND_DUMP,       32'sh0000_0000, 1'b0, '{32'sh0, ST_OK, 1'b0, 1'b0}},
      '{KIND_POP_FRONT,  32'sh0000_0000, 1'b0, '{32'sh0, ST_OK, 1'b0, 1'b0}},
      '{KIND_POP_BACK,   32'sh0000_0000, 1'b0, '{32'sh0, ST_OK, 1'b0, 1'b0}},
      // A dump of one element gives one beat in each direction.
      '{KIND_DUMP,       32'sh0000_0000, 1'b0, '{32'sh0, ST_OK, 1'b0, 1'b0}},
      '{KIND_POP_FRONT,  32'sh0000_0000, 1'b0, '{32'sh0, ST_OK, 1'b0, 1'b0}},
      '{KIND_POP_BACK,   32'sh0000_0000, 1'b1, '{32'sh0, ST_EMPTY, 1'b0, 1'b1}}
    };

    // Synchronous reset, released at a falling edge.
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_ops[r]) begin
      drive_op(directed_ops[r].kind, directed_ops[r].value);
      apply_op(directed_ops[r].kind, directed_ops[r].value);
      if (directed_ops[r].typed) begin
        void'(pending_results.pop_back());
        pending_results.push_back(directed_ops[r].want);
      end
    end

    // Random episodes. Filling and draining runs are well-formed sequences that
    // reach the full and empty boundaries; mixed runs and stray spare codes
    // make up the rest. Spare codes are not counted as operations.
    ops_sent = 0;
    while (ops_sent < RANDOM_OPS) begin
      calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          while (fill < DEPTH) begin
            run_op(pick_push());
            ops_sent++;
          end
          n = $urandom_range(1, 2);
          for (k = 0; k < n; k++) begin
            run_op(pick_push());
            ops_sent++;
          end
          if ($urandom_range(0, 1)) begin
            run_op(KIND_DUMP);
            ops_sent++;
          end
        end
        3, 4: begin
          while (fill > 0) begin
            run_op(pick_pop());
            ops_sent++;
          end
          n = $urandom_range(1, 2);
          for (k = 0; k < n; k++) begin
            run_op(pick_pop());
            ops_sent++;
          end
          if ($urandom_range(0, 1)) begin
            run_op(KIND_DUMP);
            ops_sent++;
          end
        end
        5, 6, 7: begin
          n = $urandom_range(4, 12);
          for (k = 0; k < n; k++) begin
            case ($urandom_range(0, 9))
              0, 1, 2, 3: run_op(pick_push());
              4, 5, 6, 7: run_op(pick_pop());
              default:    run_op(KIND_DUMP);
            endcase
            ops_sent++;
          end
        end
        8: begin
          run_op(KIND_DUMP);
          ops_sent++;
        end
        default: begin
          n = $urandom_range(1, 3);
          for (k = 0; k < n; k++) begin
            run_op(KIND_SPARE_A + KIND_W'($urandom_range(0, 2)));
          end
        end
      endcase
    end

    @(negedge clk);
    in_bus.valid <= 1'b0;
    calm = 1'b0;

    // Wait for every expected beat, then watch a little longer for strays.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
